FILE: rtl/core/bir_pkg.sv
// Shared types, constants and helper functions of the bicubic resampler.
// Used by every module under rtl/core; depends on nothing else.
package bir_pkg;

  localparam int DEF_MAX_WIDTH    = 128;
  localparam int DEF_MAX_HEIGHT   = 128;
  localparam int DEF_MAX_CHANNELS = 4;

  // Dividend width of the coordinate divider: a 17-bit magnitude in Q16.
  localparam int DIVW = 33;

  localparam logic [2:0] CFG_IN_WIDTH      = 3'd0;
  localparam logic [2:0] CFG_IN_HEIGHT     = 3'd1;
  localparam logic [2:0] CFG_OUT_WIDTH     = 3'd2;
  localparam logic [2:0] CFG_OUT_HEIGHT    = 3'd3;
  localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd4;

  // Weight sequencer steps: five products and a final rounding step.
  localparam logic [2:0] WGT_FF     = 3'd0;
  localparam logic [2:0] WGT_UU     = 3'd1;
  localparam logic [2:0] WGT_FUU    = 3'd2;
  localparam logic [2:0] WGT_M1     = 3'd3;
  localparam logic [2:0] WGT_M2     = 3'd4;
  localparam logic [2:0] WGT_FINISH = 3'd5;

  // 9 * 2^16, the constant term of the cubic in Q16.
  localparam logic [19:0] CUBIC_K = 20'd589824;
  localparam logic signed [13:0] W_ONE = 14'sd2048;

  typedef struct packed {
    logic       req_type;
    logic [6:0] col;
    logic [6:0] row;
    logic [1:0] channel;
    logic [7:0] sample;
  } req_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [6:0] out_col;
    logic [6:0] out_row;
    logic [1:0] out_channel;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_FIX,
    ST_WGT,
    ST_TAPS,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       div_load;
    logic       div_step;
    logic       div_fix;
    logic       wgt_step;
    logic [2:0] wgt_sel;
    logic       axis;
    logic       tap_rd;
    logic [3:0] tap_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic cmp_ok;
    logic out_free;
  } sts_t;

  // Clamp a register value to 1..hi.
  function automatic logic [7:0] clamp8(logic [7:0] v, logic [7:0] hi);
    logic [7:0] r;
    if (v == 8'd0) r = 8'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // Divide by 2^39 and round to nearest, ties to even.
  function automatic logic [14:0] rhe39(logic [53:0] m);
    logic [14:0] q;
    logic [38:0] r;
    logic [38:0] half;
    q    = m[53:39];
    r    = m[38:0];
    half = {1'b1, 38'b0};
    if (r > half || (r == half && q[0])) q = q + 15'd1;
    return q;
  endfunction

endpackage

FILE: rtl/core/bicubic_image_resampler.sv
// Bicubic (a = -0.75) image resampler over an internal frame store.
// Input channel: one request word per handshake. A store word writes one
// source byte at column, row and channel and leaves the block idle. A
// compute word yields one output word with the resampled byte and the echoed
// coordinates; out-of-range words are taken and dropped.
// A compute word runs each axis through the one-bit-a-cycle coordinate
// divider and the shared weight multiplier; the 16 taps are then read from
// the single-port frame store one a cycle, followed by a drain. The block
// takes no new word until a compute word has finished; store words are
// taken one per cycle while the block is idle.
// A finished word waits in the output register; input ready drops only while
// a compute is in flight, and a stalled receiver holds the block in its final
// step until the output register frees.
// Reset restores the size registers and clears all control state; the frame
// store is not cleared and must be written before it is read. The user must
// write configuration only while idle; the block does not enforce it.
// Depends on bir_pkg, bir_ctrl and bir_datapath.
module bicubic_image_resampler #(
  parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bir_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bir_pkg::rsp_t out_data_o
);

  bir_pkg::cmd_t cmd;
  bir_pkg::sts_t sts;

  bir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bir_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/core/bir_ctrl.sv
// Sequencer of the bicubic resampler: divider, weight and tap phases.
// Depends on bir_pkg; drives bir_datapath through cmd_t.
module bir_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bir_pkg::sts_t    sts_i,
  output bir_pkg::cmd_t    cmd_o
);

  bir_pkg::state_e state_q, state_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bir_pkg::ST_IDLE;
      cnt_q   <= 6'd0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    unique case (state_q)
      bir_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.cmp_ok) begin
          state_d = bir_pkg::ST_DIV_LOAD;
          axis_d  = 1'b0;
        end
      end
      bir_pkg::ST_DIV_LOAD: begin
        state_d = bir_pkg::ST_DIV_RUN;
        cnt_d   = 6'd0;
      end
      bir_pkg::ST_DIV_RUN: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(bir_pkg::DIVW - 1)) state_d = bir_pkg::ST_DIV_FIX;
      end
      bir_pkg::ST_DIV_FIX: begin
        state_d = bir_pkg::ST_WGT;
        cnt_d   = 6'd0;
      end
      bir_pkg::ST_WGT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[2:0] == bir_pkg::WGT_FINISH) begin
          cnt_d = 6'd0;
          if (axis_q) begin
            state_d = bir_pkg::ST_TAPS;
          end else begin
            axis_d  = 1'b1;
            state_d = bir_pkg::ST_DIV_LOAD;
          end
        end
      end
      bir_pkg::ST_TAPS: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd15) begin
          state_d = bir_pkg::ST_FLUSH;
          cnt_d   = 6'd0;
        end
      end
      bir_pkg::ST_FLUSH: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd1) state_d = bir_pkg::ST_DONE;
      end
      bir_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = bir_pkg::ST_IDLE;
      end
      default: state_d = bir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.axis       = axis_q;
    cmd_o.wgt_sel    = cnt_q[2:0];
    cmd_o.tap_idx    = cnt_q[3:0];
    unique case (state_q)
      bir_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bir_pkg::ST_DIV_LOAD: cmd_o.div_load = 1'b1;
      bir_pkg::ST_DIV_RUN:  cmd_o.div_step = 1'b1;
      bir_pkg::ST_DIV_FIX:  cmd_o.div_fix  = 1'b1;
      bir_pkg::ST_WGT:      cmd_o.wgt_step = 1'b1;
      bir_pkg::ST_TAPS:     cmd_o.tap_rd   = 1'b1;
      bir_pkg::ST_FLUSH:    cmd_o.tap_rd   = 1'b0;
      bir_pkg::ST_DONE:     cmd_o.out_load = sts_i.out_free;
      default:              cmd_o.tap_rd   = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/bir_datapath.sv
// Datapath of the bicubic resampler: registers, frame store, divider,
// weight multiplier, tap accumulator and output register. Depends on bir_pkg.
module bir_datapath #(
  parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i,
  input  bir_pkg::req_t in_data_i,
  input  bir_pkg::cmd_t cmd_i,
  output bir_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bir_pkg::rsp_t out_data_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int AW    = $clog2(Depth);
  localparam int WLim  = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
  localparam int HLim  = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam logic [7:0] WMax = 8'(WLim);
  localparam logic [7:0] HMax = 8'(HLim);
  localparam logic [7:0] CMax = 8'(MAX_CHANNELS);
  localparam logic [7:0] WRst = 8'((WLim < 128) ? WLim : 128);
  localparam logic [7:0] HRst = 8'((HLim < 128) ? HLim : 128);

  // Configuration registers.
  logic [7:0] in_w_q, in_h_q, out_w_q, out_h_q;
  logic [2:0] cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_w_q  <= WRst;
      in_h_q  <= HRst;
      out_w_q <= WRst;
      out_h_q <= HRst;
      cc_q    <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bir_pkg::CFG_IN_WIDTH:      in_w_q  <= bir_pkg::clamp8(cfg_wdata_i, WMax);
        bir_pkg::CFG_IN_HEIGHT:     in_h_q  <= bir_pkg::clamp8(cfg_wdata_i, HMax);
        bir_pkg::CFG_OUT_WIDTH:     out_w_q <= bir_pkg::clamp8(cfg_wdata_i, WMax);
        bir_pkg::CFG_OUT_HEIGHT:    out_h_q <= bir_pkg::clamp8(cfg_wdata_i, HMax);
        bir_pkg::CFG_CHANNEL_COUNT:
          cc_q <= 3'(bir_pkg::clamp8({5'b0, cfg_wdata_i[2:0]}, CMax));
        default: ;
      endcase
    end
  end

  logic ch_ok, store_ok;
  assign ch_ok    = {1'b0, in_data_i.channel} < cc_q;
  assign store_ok = !in_data_i.req_type && ch_ok &&
                    ({1'b0, in_data_i.col} < in_w_q) && ({1'b0, in_data_i.row} < in_h_q);
  assign sts_o.cmp_ok = in_data_i.req_type && ch_ok &&
                        ({1'b0, in_data_i.col} < out_w_q) && ({1'b0, in_data_i.row} < out_h_q);

  // Request being worked on.
  logic [6:0] col_q, row_q;
  logic [1:0] ch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q <= in_data_i.col;
      row_q <= in_data_i.row;
      ch_q  <= in_data_i.channel;
    end
  end

  // Coordinate divider: restoring, one quotient bit a cycle.
  logic [7:0]         ax_o, ax_in, ax_out;
  logic [15:0]        odd_prod;
  logic signed [17:0] num;
  logic [16:0]        mag;
  logic [bir_pkg::DIVW-1:0] quo_q;
  logic [8:0]         rem_q, den_q;
  logic               neg_q;
  logic [9:0]         trial;
  logic               ge;
  logic [33:0]        qinc, cval;
  logic signed [9:0]  origin_q;
  logic [15:0]        f_q;

  assign ax_o     = cmd_i.axis ? {1'b0, row_q} : {1'b0, col_q};
  assign ax_in    = cmd_i.axis ? in_h_q : in_w_q;
  assign ax_out   = cmd_i.axis ? out_h_q : out_w_q;
  assign odd_prod = {ax_o[6:0], 1'b1} * ax_in;
  assign num      = $signed({2'b0, odd_prod}) - $signed({10'b0, ax_out});
  assign mag      = num[17] ? 17'(-num) : num[16:0];
  assign trial    = {rem_q, quo_q[bir_pkg::DIVW-1]};
  assign ge       = trial >= {1'b0, den_q};
  assign qinc     = {1'b0, quo_q} + {33'b0, (neg_q && rem_q != 9'd0)};
  assign cval     = neg_q ? 34'(-qinc) : qinc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q <= {mag, 16'b0};
      rem_q <= 9'd0;
      den_q <= {ax_out, 1'b0};
      neg_q <= num[17];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[bir_pkg::DIVW-2:0], ge};
      rem_q <= ge ? 9'(trial - {1'b0, den_q}) : trial[8:0];
    end
    if (cmd_i.div_fix) begin
      // Floor of the Q16 coordinate splits into origin and fraction.
      origin_q <= $signed(cval[25:16]);
      f_q      <= cval[15:0];
    end
  end

  // Weight sequencer: one shared multiplier, product registered each step.
  logic [16:0] u;
  logic [19:0] mul_a;
  logic [33:0] mul_b;
  logic [53:0] prod;
  logic [31:0] ff_q;
  logic [33:0] uu_q;
  logic [49:0] fuu_q;
  logic [51:0] m1_q;
  logic [53:0] m2_q;
  logic [51:0] m0;
  logic [14:0] q0, q1, q2;
  logic signed [13:0] w0, w1, w2, w3;
  logic signed [13:0] wx_q [4];
  logic signed [13:0] wy_q [4];
  logic [7:0]         xs_q [4];
  logic [7:0]         ys_q [4];
  logic [7:0]         idx  [4];
  logic signed [10:0] lim;

  assign u = 17'h10000 - {1'b0, f_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.wgt_sel)
      bir_pkg::WGT_FF: begin
        mul_a = {4'b0, f_q};
        mul_b = {18'b0, f_q};
      end
      bir_pkg::WGT_UU: begin
        mul_a = {3'b0, u};
        mul_b = {17'b0, u};
      end
      bir_pkg::WGT_FUU: begin
        mul_a = {4'b0, f_q};
        mul_b = uu_q;
      end
      bir_pkg::WGT_M1: begin
        mul_a = bir_pkg::CUBIC_K - ({2'b0, f_q, 2'b0} + {4'b0, f_q});
        mul_b = {2'b0, ff_q};
      end
      bir_pkg::WGT_M2: begin
        mul_a = bir_pkg::CUBIC_K - ({1'b0, u, 2'b0} + {3'b0, u});
        mul_b = uu_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign m0   = {2'b0, fuu_q} + {1'b0, fuu_q, 1'b0};
  assign q0   = bir_pkg::rhe39({2'b0, m0});
  assign q1   = bir_pkg::rhe39({2'b0, m1_q});
  assign q2   = bir_pkg::rhe39(m2_q);
  // Every cubic term is non-positive, so rounding works on magnitudes.
  assign w0   = -$signed(14'(q0));
  assign w1   = bir_pkg::W_ONE - $signed(14'(q1));
  assign w2   = bir_pkg::W_ONE - $signed(14'(q2));
  assign w3   = bir_pkg::W_ONE - w0 - w1 - w2;
  assign lim  = $signed({3'b0, ax_in}) - 11'sd1;

  always_comb begin
    logic signed [10:0] v;
    for (int k = 0; k < 4; k++) begin
      v = 11'(origin_q) + 11'(k) - 11'sd1;
      if (v < 11'sd0) idx[k] = 8'd0;
      else if (v > lim) idx[k] = lim[7:0];
      else idx[k] = v[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wgt_step) begin
      unique case (cmd_i.wgt_sel)
        bir_pkg::WGT_FF:  ff_q  <= prod[31:0];
        bir_pkg::WGT_UU:  uu_q  <= prod[33:0];
        bir_pkg::WGT_FUU: fuu_q <= prod[49:0];
        bir_pkg::WGT_M1:  m1_q  <= prod[51:0];
        bir_pkg::WGT_M2:  m2_q  <= prod;
        bir_pkg::WGT_FINISH: begin
          if (cmd_i.axis) begin
            wy_q[0] <= w0;
            wy_q[1] <= w1;
            wy_q[2] <= w2;
            wy_q[3] <= w3;
            for (int k = 0; k < 4; k++) ys_q[k] <= idx[k];
          end else begin
            wx_q[0] <= w0;
            wx_q[1] <= w1;
            wx_q[2] <= w2;
            wx_q[3] <= w3;
            for (int k = 0; k < 4; k++) xs_q[k] <= idx[k];
          end
        end
        default: ;
      endcase
    end
  end

  // Frame store: single port, read data registered.
  logic [7:0]    mem [Depth];
  logic [7:0]    rd_q;
  logic [AW-1:0] waddr, raddr, maddr;
  logic          we;

  assign we    = cmd_i.accept && store_ok;
  assign waddr = AW'((32'(in_data_i.row) * MAX_WIDTH + 32'(in_data_i.col)) * MAX_CHANNELS
                     + 32'(in_data_i.channel));
  assign raddr = AW'((32'(ys_q[cmd_i.tap_idx[3:2]]) * MAX_WIDTH
                     + 32'(xs_q[cmd_i.tap_idx[1:0]])) * MAX_CHANNELS + 32'(ch_q));
  assign maddr = cmd_i.tap_rd ? raddr : waddr;

  always_ff @(posedge clk_i) begin
    if (we) mem[maddr] <= in_data_i.sample;
    if (cmd_i.tap_rd) rd_q <= mem[maddr];
  end

  // Tap accumulator: row sums first, then weighted by the row weight.
  logic               tapv_q, hv_q;
  logic [3:0]         tapi_q;
  logic signed [22:0] pb;
  logic signed [24:0] h_d, h_q, hrow_q;
  logic [1:0]         hj_q;
  logic signed [40:0] sum_q;
  logic signed [41:0] rnd;
  logic [7:0]         pix;

  assign pb  = $signed({1'b0, rd_q}) * wx_q[tapi_q[1:0]];
  assign h_d = ((tapi_q[1:0] == 2'd0) ? 25'sd0 : h_q) + 25'(pb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tapv_q <= 1'b0;
      hv_q   <= 1'b0;
    end else begin
      tapv_q <= cmd_i.tap_rd;
      hv_q   <= tapv_q && (tapi_q[1:0] == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    tapi_q <= cmd_i.tap_idx;
    if (tapv_q) begin
      h_q <= h_d;
      if (tapi_q[1:0] == 2'd3) begin
        hrow_q <= h_d;
        hj_q   <= tapi_q[3:2];
      end
    end
    if (cmd_i.tap_rd && cmd_i.tap_idx == 4'd0) sum_q <= '0;
    else if (hv_q) sum_q <= sum_q + 41'(hrow_q * wy_q[hj_q]);
  end

  assign rnd = 42'(sum_q) + 42'sd2097152;

  always_comb begin
    if (rnd[41]) pix = 8'd0;
    else if (rnd[40:30] != 11'd0) pix = 8'd255;
    else pix = rnd[29:22];
  end

  // Output register.
  logic          out_valid_q;
  bir_pkg::rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pixel_out   <= pix;
      out_q.out_col     <= col_q;
      out_q.out_row     <= row_q;
      out_q.out_channel <= ch_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

FILE: rtl/core/bir_checker.sv
// Port-level checks of the bicubic resampler, bound to the top level.
// Depends on bir_pkg and bicubic_image_resampler.
module bir_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input bir_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input bir_pkg::rsp_t out_data_o
);

  // A stalled output word stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // A store word never blocks the next one.
  a_store_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.req_type |=> in_ready_o)
    else $error("input blocked after a store word");

  // A new result only appears while a compute is in flight.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("output word raised while idle");

endmodule

bind bicubic_image_resampler bir_checker u_bir_checker (.*);
